// ===== design/fce_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the FAT chain engine.
package fce_pkg;

  localparam int FAT_ENTRIES = 1024;
  localparam int ADDR_W      = $clog2(FAT_ENTRIES);
  localparam int ENTRY_W     = 11;
  localparam int LEN_W       = 11;
  localparam int OFS_W       = 26;
  localparam int SHIFT_W     = 5;

  localparam logic [ENTRY_W-1:0] FAT_EOC  = '1;
  localparam logic [ENTRY_W-1:0] FAT_FREE = '0;
  localparam logic [ADDR_W-1:0]  ADDR_MAX = ADDR_W'(FAT_ENTRIES - 1);
  localparam logic [LEN_W-1:0]   LEN_MAX  = LEN_W'(FAT_ENTRIES);
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd10;

  // operation codes
  localparam logic [2:0] OP_ALLOC    = 3'd0;
  localparam logic [2:0] OP_EXTEND   = 3'd1;
  localparam logic [2:0] OP_TRUNCATE = 3'd2;
  localparam logic [2:0] OP_SEEK     = 3'd3;
  localparam logic [2:0] OP_WALK     = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD      = 2'd2;
  localparam logic [1:0] ST_SEEK_END = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_WALK_A, S_WALK_D, S_EVAL,
    S_SCAN, S_SCAN_CHK, S_LINK, S_LINK_END, S_TR_A, S_TR_D
  } state_t;

  // where block and chain_length of a result come from
  typedef enum logic [2:0] {
    SRC_ZERO, SRC_TAIL, SRC_SEEK, SRC_NEWTAIL, SRC_PICK
  } src_t;

  typedef struct packed {
    logic       clr;
    logic       load;
    logic       init_walk;
    logic       walk_rd;
    logic       walk_step;
    logic       init_scan;
    logic       init_link;
    logic       scan_run;
    logic       init_tr;
    logic       tr_rd;
    logic       tr_step;
    logic       link_end;
    logic       finish;
    logic [1:0] fin_status;
    src_t       fin_src;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic [2:0] op;
    logic       start_ok;
    logic       cnt_zero;
    logic       cnt_big;
    logic       walk_end;
    logic       scan_end;
    logic       scan_short;
    logic       trunc_bad;
    logic       seek_past;
    logic       tr_end;
  } stat_t;

endpackage

// ===== design/fce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/fce_ctrl.sv =====
// Controller state machine of the FAT chain engine.
module fce_ctrl import fce_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t st,
  output logic  busy,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:    if (st.clr_done) state_nxt = S_IDLE;
      S_IDLE:     if (start) state_nxt = S_DECODE;
      S_DECODE: begin
        if (st.op == OP_ALLOC) begin
          state_nxt = (st.cnt_zero || st.cnt_big) ? S_IDLE : S_SCAN;
        end else if (st.op > OP_WALK || !st.start_ok) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_WALK_A;
        end
      end
      S_WALK_A:   state_nxt = S_WALK_D;
      S_WALK_D:   state_nxt = st.walk_end ? S_EVAL : S_WALK_A;
      S_EVAL: begin
        state_nxt = S_IDLE;
        if (st.op == OP_EXTEND && !st.cnt_zero && !st.cnt_big) state_nxt = S_SCAN;
        if (st.op == OP_TRUNCATE && !st.trunc_bad && !st.cnt_zero) state_nxt = S_TR_A;
      end
      S_SCAN:     if (st.scan_end) state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: state_nxt = st.scan_short ? S_IDLE : S_LINK;
      S_LINK:     if (st.scan_end) state_nxt = S_LINK_END;
      S_LINK_END: state_nxt = S_IDLE;
      S_TR_A:     state_nxt = S_TR_D;
      S_TR_D:     state_nxt = st.tr_end ? S_IDLE : S_TR_A;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    cmd.fin_status = ST_OK;
    cmd.fin_src = SRC_ZERO;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_CLEAR: cmd.clr = 1'b1;
      S_IDLE:  cmd.load = start;
      S_DECODE: begin
        if (st.op == OP_ALLOC) begin
          if (st.cnt_zero) begin
            cmd.finish = 1'b1;
            cmd.fin_status = ST_BAD;
          end else if (st.cnt_big) begin
            cmd.finish = 1'b1;
            cmd.fin_status = ST_NO_SPACE;
          end else begin
            cmd.init_scan = 1'b1;
          end
        end else if (st.op > OP_WALK || !st.start_ok) begin
          cmd.finish = 1'b1;
          cmd.fin_status = ST_BAD;
        end else begin
          cmd.init_walk = 1'b1;
        end
      end
      S_WALK_A: cmd.walk_rd = 1'b1;
      S_WALK_D: cmd.walk_step = 1'b1;
      S_EVAL: begin
        cmd.fin_src = SRC_TAIL;
        priority case (st.op)
          OP_EXTEND: begin
            if (st.cnt_zero) begin
              cmd.finish = 1'b1;
              cmd.fin_status = ST_BAD;
            end else if (st.cnt_big) begin
              cmd.finish = 1'b1;
              cmd.fin_status = ST_NO_SPACE;
            end else begin
              cmd.init_scan = 1'b1;
            end
          end
          OP_TRUNCATE: begin
            if (st.trunc_bad) begin
              cmd.finish = 1'b1;
              cmd.fin_status = ST_BAD;
            end else if (st.cnt_zero) begin
              cmd.finish = 1'b1;
            end else begin
              cmd.init_tr = 1'b1;
            end
          end
          OP_SEEK: begin
            cmd.finish = 1'b1;
            if (st.seek_past) begin
              cmd.fin_status = ST_SEEK_END;
            end else begin
              cmd.fin_src = SRC_SEEK;
            end
          end
          default: cmd.finish = 1'b1;
        endcase
      end
      S_SCAN: cmd.scan_run = 1'b1;
      S_SCAN_CHK: begin
        if (st.scan_short) begin
          cmd.finish = 1'b1;
          cmd.fin_status = ST_NO_SPACE;
          cmd.fin_src = (st.op == OP_ALLOC) ? SRC_ZERO : SRC_TAIL;
        end else begin
          cmd.init_link = 1'b1;
        end
      end
      S_LINK: cmd.scan_run = 1'b1;
      S_LINK_END: begin
        cmd.link_end = 1'b1;
        cmd.finish = 1'b1;
        cmd.fin_src = SRC_PICK;
      end
      S_TR_A: cmd.tr_rd = 1'b1;
      S_TR_D: begin
        cmd.tr_step = 1'b1;
        if (st.tr_end) begin
          cmd.finish = 1'b1;
          cmd.fin_src = SRC_NEWTAIL;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== design/fce_dp.sv =====
// Datapath of the FAT chain engine: table RAM, chain walker, free scanner, result registers.
module fce_dp import fce_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              st,
  input  logic [2:0]         in_op,
  input  logic [ADDR_W-1:0]  in_start_block,
  input  logic [LEN_W-1:0]   in_count,
  input  logic [OFS_W-1:0]   in_byte_offset,
  input  logic               cfg_valid,
  input  logic [SHIFT_W-1:0] cfg_data,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [ADDR_W-1:0]  out_block,
  output logic [LEN_W-1:0]   out_chain_length
);

  // control registers
  logic [ADDR_W-1:0]  clr_cnt_r;
  logic [SHIFT_W-1:0] shift_r;
  logic               out_valid_r;
  logic               dv_r;
  logic               issued_r;
  logic               link_mode_r;

  // payload registers
  logic [2:0]         op_r;
  logic [ADDR_W-1:0]  start_r;
  logic [LEN_W-1:0]   count_r;
  logic [OFS_W-1:0]   hops_r;
  logic [ADDR_W-1:0]  cur_r;
  logic [LEN_W-1:0]   len_r;
  logic [ADDR_W-1:0]  tail_r;
  logic [ADDR_W-1:0]  seek_blk_r;
  logic [ADDR_W-1:0]  icnt_r;
  logic [ADDR_W-1:0]  daddr_r;
  logic [LEN_W-1:0]   got_r;
  logic [ADDR_W-1:0]  prev_r;
  logic               prev_v_r;
  logic [ADDR_W-1:0]  first_r;
  logic [LEN_W-1:0]   idx_r;
  logic [LEN_W-1:0]   keep_r;
  logic [ADDR_W-1:0]  newtail_r;
  logic [1:0]         out_status_r;
  logic [ADDR_W-1:0]  out_block_r;
  logic [LEN_W-1:0]   out_len_r;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ADDR_W-1:0]  raddr;
  logic [ENTRY_W-1:0] rdata;

  logic [LEN_W-1:0]   len_m1;
  logic [LEN_W-1:0]   keep_m1;
  logic               issue;
  logic               free_hit;
  logic               link_wr;
  logic               tr_wr;

  fce_ram #(.WIDTH(ENTRY_W), .DEPTH(FAT_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign len_m1  = len_r - LEN_W'(1);
  assign keep_m1 = keep_r - LEN_W'(1);
  assign issue   = cmd.scan_run && !issued_r;

  // a scanned entry that is free, not the chain's own tail, and still wanted
  assign free_hit = dv_r && (rdata == FAT_FREE) && (got_r < count_r) &&
                    !((op_r == OP_EXTEND) && (daddr_r == tail_r));
  assign link_wr  = link_mode_r && free_hit && prev_v_r;
  assign tr_wr    = cmd.tr_step && (idx_r >= keep_m1);

  // read address: chain reads follow cur, scans use the running index
  assign raddr = (cmd.walk_rd || cmd.tr_rd) ? cur_r : icnt_r;

  // write port
  always_comb begin
    we    = 1'b0;
    waddr = cur_r;
    wdata = FAT_FREE;
    priority if (cmd.clr) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdata = (clr_cnt_r == '0) ? FAT_EOC : FAT_FREE;
    end else if (cmd.link_end) begin
      we    = 1'b1;
      waddr = prev_r;
      wdata = FAT_EOC;
    end else if (link_wr) begin
      we    = 1'b1;
      waddr = prev_r;
      wdata = {1'b0, daddr_r};
    end else if (tr_wr) begin
      we    = 1'b1;
      waddr = cur_r;
      wdata = (idx_r == keep_m1) ? FAT_EOC : FAT_FREE;
    end else begin
      we    = 1'b0;
    end
  end

  // status to the controller
  always_comb begin
    st.clr_done   = (clr_cnt_r == ADDR_MAX);
    st.op         = op_r;
    st.start_ok   = (start_r != '0);
    st.cnt_zero   = (count_r == '0);
    st.cnt_big    = (count_r >= LEN_MAX);
    st.walk_end   = (rdata == FAT_FREE) || (rdata >= ENTRY_W'(FAT_ENTRIES)) ||
                    (len_r == LEN_MAX);
    st.scan_end   = dv_r && (daddr_r == ADDR_MAX);
    st.scan_short = (got_r < count_r);
    st.trunc_bad  = (count_r >= len_r);
    st.seek_past  = (hops_r >= {{(OFS_W-LEN_W){1'b0}}, len_r});
    st.tr_end     = (idx_r == len_m1);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      shift_r     <= SHIFT_RESET;
      out_valid_r <= 1'b0;
      dv_r        <= 1'b0;
      issued_r    <= 1'b0;
      link_mode_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      if (cfg_valid) shift_r <= cfg_data;
      out_valid_r <= cmd.finish;
      dv_r        <= issue;
      if (cmd.init_scan || cmd.init_link) begin
        issued_r <= 1'b0;
      end else if (issue && icnt_r == ADDR_MAX) begin
        issued_r <= 1'b1;
      end
      if (cmd.init_scan) link_mode_r <= 1'b0;
      if (cmd.init_link) link_mode_r <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      start_r <= in_start_block;
      count_r <= in_count;
      hops_r  <= in_byte_offset >> shift_r;
    end
    // chain walk
    if (cmd.init_walk) begin
      cur_r <= start_r;
      len_r <= LEN_W'(1);
    end
    if (cmd.walk_step) begin
      if (hops_r == {{(OFS_W-LEN_W){1'b0}}, len_m1}) seek_blk_r <= cur_r;
      if (st.walk_end) begin
        tail_r <= cur_r;
      end else begin
        cur_r <= rdata[ADDR_W-1:0];
        len_r <= len_r + LEN_W'(1);
      end
    end
    // free scan and link passes
    if (cmd.init_scan || cmd.init_link) begin
      icnt_r   <= ADDR_W'(1);
      got_r    <= '0;
      prev_r   <= tail_r;
      prev_v_r <= (op_r == OP_EXTEND);
    end
    if (issue) begin
      icnt_r  <= icnt_r + ADDR_W'(1);
      daddr_r <= icnt_r;
    end
    if (free_hit) begin
      got_r <= got_r + LEN_W'(1);
      if (link_mode_r) begin
        prev_r   <= daddr_r;
        prev_v_r <= 1'b1;
        if (got_r == '0) first_r <= daddr_r;
      end
    end
    // truncate pass
    if (cmd.init_tr) begin
      cur_r  <= start_r;
      idx_r  <= '0;
      keep_r <= len_r - count_r;
    end
    if (cmd.tr_step) begin
      if (idx_r == keep_m1) newtail_r <= cur_r;
      cur_r <= rdata[ADDR_W-1:0];
      idx_r <= idx_r + LEN_W'(1);
    end
    // result word
    if (cmd.finish) begin
      out_status_r <= cmd.fin_status;
      unique case (cmd.fin_src)
        SRC_TAIL: begin
          out_block_r <= tail_r;
          out_len_r   <= len_r;
        end
        SRC_SEEK: begin
          out_block_r <= seek_blk_r;
          out_len_r   <= len_r;
        end
        SRC_NEWTAIL: begin
          out_block_r <= (idx_r == keep_m1) ? cur_r : newtail_r;
          out_len_r   <= keep_r;
        end
        SRC_PICK: begin
          out_block_r <= first_r;
          out_len_r   <= (op_r == OP_ALLOC) ? count_r : len_r + count_r;
        end
        default: begin
          out_block_r <= '0;
          out_len_r   <= '0;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_block        = out_block_r;
  assign out_chain_length = out_len_r;

endmodule

// ===== design/fat_chain_engine.sv =====
// Top level of the FAT chain engine: controller, datapath and configuration port.
//
// Issue a word with start while busy is low; exactly one result word comes back
// on out_valid for one cycle and cannot be held off. After reset the table is
// cleared by a pass over all 1024 entries, during which busy stays high. Walk and
// seek make one dependent table read per chain block; truncate walks the chain
// twice; allocate scans the table twice at one read per cycle; extend adds its
// chain walk to that. Errors caught on the request alone finish from the decode
// state without a table access. block_shift is to be written on the cfg port
// (always ready) only while the block is idle; the block does not enforce this.
module fat_chain_engine import fce_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_op,
  input  logic [ADDR_W-1:0]  in_start_block,
  input  logic [LEN_W-1:0]   in_count,
  input  logic [OFS_W-1:0]   in_byte_offset,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SHIFT_W-1:0] cfg_data,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [ADDR_W-1:0]  out_block,
  output logic [LEN_W-1:0]   out_chain_length
);

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  fce_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .busy  (busy),
    .cmd   (cmd)
  );

  fce_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_op            (in_op),
    .in_start_block   (in_start_block),
    .in_count         (in_count),
    .in_byte_offset   (in_byte_offset),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_block        (out_block),
    .out_chain_length (out_chain_length)
  );

`ifndef SYNTHESIS
  // an accepted word makes the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low after accepted word");

  // a good result always names a chain of at least one block
  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK) |-> (out_chain_length != '0))
    else $error("ok result with empty chain");

  // result strobes never come back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  // a seek-past-end result still names a chain of at least one block
  a_seek_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_SEEK_END) |-> (out_chain_length != '0))
    else $error("seek-past-end without a chain");
`endif

endmodule
